// File: src/rwnh_pkg.sv
// Shared types, constants and helpers for the ray wall nearest hit block.
// No dependencies; imported by every module of the block.
package rwnh_pkg;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_WALLS  = 6;
  localparam int DIV_STEPS  = 32;
  // divider: one input stage, one stage per quotient bit, one round/saturate stage
  localparam int DIV_LAT    = DIV_STEPS + 2;
  // stages up to and including the nearest-wall tree
  localparam int SEL_STAGES = 10;
  // request edge to result edge
  localparam int OUT_LAT    = SEL_STAGES + 1 + DIV_LAT + 1;
  // reach limit 4.0 in Q15.16 is 2^18
  localparam int REACH_BITS = 18;

  localparam logic [REG_IDX_W-1:0] REG_X_HIGH         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_LOW          = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_RIGHT        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_X_FAR          = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_Y_BOTTOM       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Y_TOP          = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_Y_TOP_RIGHT    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_Y_BOTTOM_RIGHT = 3'd7;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;
  localparam logic FACE_NEG = 1'b0;
  localparam logic FACE_POS = 1'b1;

  typedef struct packed {
    logic                 axis;
    logic                 face_pos;
    logic [REG_IDX_W-1:0] plane;
    logic [REG_IDX_W-1:0] upper;
    logic [REG_IDX_W-1:0] lower;
  } wall_def_t;

  typedef struct packed {
    logic        found;
    logic [31:0] num;
    logic [31:0] den;
  } cand_t;

  typedef struct packed {
    logic [2:0][32:0] dir;
    logic [2:0][31:0] cam;
  } ray_t;

  // walls in priority order: BL, CL, TL, TR, CR, BR
  function automatic wall_def_t wall_def(input int idx);
    wall_def_t w;
    case (idx)
      0: w = '{AXIS_Y, FACE_NEG, REG_Y_BOTTOM,       REG_X_HIGH,   REG_X_LOW};
      1: w = '{AXIS_X, FACE_NEG, REG_X_HIGH,         REG_Y_BOTTOM, REG_Y_TOP};
      2: w = '{AXIS_Y, FACE_POS, REG_Y_TOP,          REG_X_HIGH,   REG_X_LOW};
      3: w = '{AXIS_Y, FACE_POS, REG_Y_TOP_RIGHT,    REG_X_FAR,    REG_X_RIGHT};
      4: w = '{AXIS_X, FACE_POS, REG_X_RIGHT,        REG_Y_BOTTOM, REG_Y_TOP};
      5: w = '{AXIS_Y, FACE_NEG, REG_Y_BOTTOM_RIGHT, REG_X_FAR,    REG_X_RIGHT};
      default: w = '{AXIS_X, FACE_POS, REG_X_HIGH, REG_X_HIGH, REG_X_HIGH};
    endcase
    return w;
  endfunction

  // earlier candidate a keeps ties; cross_a = a.num*b.den, cross_b = b.num*a.den
  function automatic cand_t pick(input cand_t a, input cand_t b,
                                 input logic [63:0] cross_a, input logic [63:0] cross_b);
    cand_t r;
    r = a;
    if (b.found && (!a.found || (cross_b < cross_a))) r = b;
    return r;
  endfunction

endpackage

// File: src/rwnh_div.sv
// Pipelined rounding divider for one hit coordinate: cam +/- round(prod/den), saturated.
// Depends on rwnh_pkg (DIV_STEPS).
module rwnh_div import rwnh_pkg::*; (
  input  logic        clk,
  input  logic [63:0] prod_i,
  input  logic [31:0] den_i,
  input  logic [31:0] cam_i,
  input  logic        neg_i,
  output logic [31:0] coord_o
);

  logic [31:0] rem_r [DIV_STEPS+1];
  logic [31:0] low_r [DIV_STEPS+1];
  logic [31:0] quo_r [DIV_STEPS+1];
  logic [31:0] den_r [DIV_STEPS+1];
  logic [31:0] cam_r [DIV_STEPS+1];
  logic        neg_r [DIV_STEPS+1];
  logic        ovf_r [DIV_STEPS+1];
  logic [31:0] rem_nxt [DIV_STEPS];
  logic [31:0] quo_nxt [DIV_STEPS];
  logic [31:0] coord_r, coord_nxt;

  // one quotient bit per stage
  always_comb begin
    logic [32:0] trial;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_r[k], low_r[k][31]};
      if (trial >= {1'b0, den_r[k]}) begin
        rem_nxt[k] = 32'(trial - {1'b0, den_r[k]});
        quo_nxt[k] = {quo_r[k][30:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[31:0];
        quo_nxt[k] = {quo_r[k][30:0], 1'b0};
      end
    end
  end

  // round half away from zero on the magnitude, then apply sign and saturate
  always_comb begin
    logic        round_up;
    logic [32:0] mag;
    logic signed [33:0] sum;
    round_up = {rem_r[DIV_STEPS], 1'b0} >= {1'b0, den_r[DIV_STEPS]};
    if (ovf_r[DIV_STEPS]) mag = {1'b1, 32'd0};
    else mag = {1'b0, quo_r[DIV_STEPS]} + {32'd0, round_up};
    if (neg_r[DIV_STEPS])
      sum = $signed({{2{cam_r[DIV_STEPS][31]}}, cam_r[DIV_STEPS]}) - $signed({1'b0, mag});
    else
      sum = $signed({{2{cam_r[DIV_STEPS][31]}}, cam_r[DIV_STEPS]}) + $signed({1'b0, mag});
    if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111)) coord_nxt = sum[31:0];
    else if (sum[33]) coord_nxt = 32'h8000_0000;
    else coord_nxt = 32'h7fff_ffff;
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= prod_i[63:32];
    low_r[0] <= prod_i[31:0];
    quo_r[0] <= '0;
    den_r[0] <= den_i;
    cam_r[0] <= cam_i;
    neg_r[0] <= neg_i;
    ovf_r[0] <= prod_i[63:32] >= den_i;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_r[k+1] <= rem_nxt[k];
      low_r[k+1] <= {low_r[k][30:0], 1'b0};
      quo_r[k+1] <= quo_nxt[k];
      den_r[k+1] <= den_r[k];
      cam_r[k+1] <= cam_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
    coord_r <= coord_nxt;
  end

  assign coord_o = coord_r;

endmodule

// File: src/ray_wall_nearest_hit.sv
// Ray wall nearest hit: top level, wall tests, nearest-wall tree and reach test.
// Depends on rwnh_pkg and rwnh_div.
// Throughput: one request per cycle, every cycle; busy is never raised.
// The result is strobed for one cycle; the receiver cannot stall, so nothing backs up.
// Depth is set mostly by the hit coordinate dividers and their 32 one-bit-per-stage quotient stages.
// rst_n (synchronous, low) clears the wall registers to 0 and all valid bits.
module ray_wall_nearest_hit import rwnh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          in_point_x,
  input  logic [31:0]          in_point_y,
  input  logic [31:0]          in_point_z,
  input  logic [31:0]          in_est_cam_x,
  input  logic [31:0]          in_est_cam_y,
  input  logic [31:0]          in_est_cam_z,
  input  logic [31:0]          in_true_cam_x,
  input  logic [31:0]          in_true_cam_y,
  input  logic [31:0]          in_true_cam_z,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  output logic [31:0]          out_hit_x,
  output logic [31:0]          out_hit_y,
  output logic [31:0]          out_hit_z,
  output logic                 out_hit_found,
  output logic                 out_within_reach
);

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // wall registers; the user must write them only while the pipe is empty, the block itself does not enforce this
  logic [31:0] cfg_regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_regs_r[i] <= '0;
    end else if (cfg_we) begin
      cfg_regs_r[cfg_index] <= cfg_wdata;
    end
  end

  // fully pipelined, never holds a request off
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: direction d = point - est_cam (33 bit), true camera is the origin.
  // Ray and valid travel with every stage up to the end of the tree.
  // ---------------------------------------------------------------------------
  logic vld_r [SEL_STAGES];
  ray_t ray_r [SEL_STAGES];
  ray_t ray_nxt;

  always_comb begin
    ray_nxt.dir[0] = {in_point_x[31], in_point_x} - {in_est_cam_x[31], in_est_cam_x};
    ray_nxt.dir[1] = {in_point_y[31], in_point_y} - {in_est_cam_y[31], in_est_cam_y};
    ray_nxt.dir[2] = {in_point_z[31], in_point_z} - {in_est_cam_z[31], in_est_cam_z};
    ray_nxt.cam[0] = in_true_cam_x;
    ray_nxt.cam[1] = in_true_cam_y;
    ray_nxt.cam[2] = in_true_cam_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SEL_STAGES; s++) vld_r[s] <= 1'b0;
    end else begin
      vld_r[0] <= start & ~busy;
      for (int s = 1; s < SEL_STAGES; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    ray_r[0] <= ray_nxt;
    for (int s = 1; s < SEL_STAGES; s++) ray_r[s] <= ray_r[s-1];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per wall, facing test, den = |d_axis|, num = |cam_axis - plane|.
  // ---------------------------------------------------------------------------
  logic        fac_r [NUM_WALLS];
  logic [31:0] num_r [NUM_WALLS];
  logic [31:0] den_r [NUM_WALLS];
  logic        fac_nxt [NUM_WALLS];
  logic [31:0] num_nxt [NUM_WALLS];
  logic [31:0] den_nxt [NUM_WALLS];

  always_comb begin
    wall_def_t   wd;
    logic [32:0] da;
    logic [31:0] ca;
    logic [31:0] pl;
    for (int w = 0; w < NUM_WALLS; w++) begin
      wd = wall_def(w);
      da = ray_r[0].dir[{1'b0, wd.axis}];
      ca = ray_r[0].cam[{1'b0, wd.axis}];
      pl = cfg_regs_r[wd.plane];
      if (wd.face_pos) fac_nxt[w] = !da[32] && (da != '0);
      else fac_nxt[w] = da[32];
      den_nxt[w] = mag33(da);
      num_nxt[w] = mag33({ca[31], ca} - {pl[31], pl});
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WALLS; w++) begin
      fac_r[w] <= fac_nxt[w];
      num_r[w] <= num_nxt[w];
      den_r[w] <= den_nxt[w];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: span products. The hit's off-axis coordinate times den is
  // cam_o*den + d_o*num; bounds are scaled by den to stay exact.
  // ---------------------------------------------------------------------------
  logic signed [64:0] pcam_r [NUM_WALLS];
  logic signed [65:0] pdir_r [NUM_WALLS];
  logic signed [64:0] plo_r  [NUM_WALLS];
  logic signed [64:0] phi_r  [NUM_WALLS];
  logic               fac3_r [NUM_WALLS];
  logic [31:0]        num3_r [NUM_WALLS];
  logic [31:0]        den3_r [NUM_WALLS];
  logic signed [64:0] pcam_nxt [NUM_WALLS];
  logic signed [65:0] pdir_nxt [NUM_WALLS];
  logic signed [64:0] plo_nxt  [NUM_WALLS];
  logic signed [64:0] phi_nxt  [NUM_WALLS];

  always_comb begin
    wall_def_t wd;
    for (int w = 0; w < NUM_WALLS; w++) begin
      wd = wall_def(w);
      pcam_nxt[w] = $signed(ray_r[1].cam[{1'b0, ~wd.axis}]) * $signed({1'b0, den_r[w]});
      pdir_nxt[w] = $signed(ray_r[1].dir[{1'b0, ~wd.axis}]) * $signed({1'b0, num_r[w]});
      plo_nxt[w]  = $signed(cfg_regs_r[wd.lower]) * $signed({1'b0, den_r[w]});
      phi_nxt[w]  = $signed(cfg_regs_r[wd.upper]) * $signed({1'b0, den_r[w]});
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WALLS; w++) begin
      pcam_r[w] <= pcam_nxt[w];
      pdir_r[w] <= pdir_nxt[w];
      plo_r[w]  <= plo_nxt[w];
      phi_r[w]  <= phi_nxt[w];
      fac3_r[w] <= fac_r[w];
      num3_r[w] <= num_r[w];
      den3_r[w] <= den_r[w];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: inclusive span check; a wall is a candidate if faced and in span.
  // ---------------------------------------------------------------------------
  cand_t cand4_r [NUM_WALLS];
  cand_t cand4_nxt [NUM_WALLS];

  always_comb begin
    logic signed [66:0] val;
    logic               in_span;
    for (int w = 0; w < NUM_WALLS; w++) begin
      val = 67'(pcam_r[w]) + 67'(pdir_r[w]);
      in_span = (67'(plo_r[w]) <= val) && (val <= 67'(phi_r[w]));
      cand4_nxt[w].found = fac3_r[w] && in_span;
      cand4_nxt[w].num   = num3_r[w];
      cand4_nxt[w].den   = den3_r[w];
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WALLS; w++) cand4_r[w] <= cand4_nxt[w];
  end

  // ---------------------------------------------------------------------------
  // Stages 5..10: nearest-wall tree, three levels, each a cross-multiply stage
  // then a select stage. Earlier wall wins ties, so the order BL..BR holds.
  // ---------------------------------------------------------------------------
  localparam int PAIRS = NUM_WALLS / 2;

  cand_t       l1a_r [PAIRS];
  cand_t       l1b_r [PAIRS];
  logic [63:0] l1xa_r [PAIRS];
  logic [63:0] l1xb_r [PAIRS];
  cand_t       cand6_r [PAIRS];
  cand_t       l2a_r, l2b_r, l2c_r;
  logic [63:0] l2xa_r, l2xb_r;
  cand_t       cand8_r [2];
  cand_t       l3a_r, l3b_r;
  logic [63:0] l3xa_r, l3xb_r;
  cand_t       best10_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < PAIRS; k++) begin
      l1a_r[k]  <= cand4_r[2*k];
      l1b_r[k]  <= cand4_r[2*k+1];
      l1xa_r[k] <= 64'(cand4_r[2*k].num) * 64'(cand4_r[2*k+1].den);
      l1xb_r[k] <= 64'(cand4_r[2*k+1].num) * 64'(cand4_r[2*k].den);
      cand6_r[k] <= pick(l1a_r[k], l1b_r[k], l1xa_r[k], l1xb_r[k]);
    end
    l2a_r  <= cand6_r[0];
    l2b_r  <= cand6_r[1];
    l2c_r  <= cand6_r[2];
    l2xa_r <= 64'(cand6_r[0].num) * 64'(cand6_r[1].den);
    l2xb_r <= 64'(cand6_r[1].num) * 64'(cand6_r[0].den);
    cand8_r[0] <= pick(l2a_r, l2b_r, l2xa_r, l2xb_r);
    cand8_r[1] <= l2c_r;
    l3a_r  <= cand8_r[0];
    l3b_r  <= cand8_r[1];
    l3xa_r <= 64'(cand8_r[0].num) * 64'(cand8_r[1].den);
    l3xb_r <= 64'(cand8_r[1].num) * 64'(cand8_r[0].den);
    best10_r <= pick(l3a_r, l3b_r, l3xa_r, l3xb_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 11: products for the hit point (|d_c|*num) and for the reach test
  // (|d_c|^2, den^2, num^2). num^2 is only needed when num < 2^18.
  // ---------------------------------------------------------------------------
  logic        vld11_r, found11_r;
  logic [63:0] m11_r  [3];
  logic [63:0] sq11_r [3];
  logic [31:0] cam11_r [3];
  logic        neg11_r [3];
  logic [31:0] den11_r;
  logic [63:0] densq11_r;
  logic [35:0] numsq11_r;
  logic        near11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld11_r <= 1'b0;
    end else begin
      vld11_r <= vld_r[SEL_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] mc;
    found11_r <= best10_r.found;
    for (int c = 0; c < 3; c++) begin
      mc = mag33(ray_r[SEL_STAGES-1].dir[c]);
      m11_r[c]   <= 64'(mc) * 64'(best10_r.num);
      sq11_r[c]  <= 64'(mc) * 64'(mc);
      cam11_r[c] <= ray_r[SEL_STAGES-1].cam[c];
      neg11_r[c] <= ray_r[SEL_STAGES-1].dir[c][32];
    end
    den11_r   <= best10_r.den;
    densq11_r <= 64'(best10_r.den) * 64'(best10_r.den);
    numsq11_r <= 36'(best10_r.num[REACH_BITS-1:0]) * 36'(best10_r.num[REACH_BITS-1:0]);
    near11_r  <= best10_r.num[31:REACH_BITS] == '0;
  end

  // ---------------------------------------------------------------------------
  // Stages 12..14: reach test |d|^2 * num^2 < den^2 * 2^36, exact.
  // The 66-bit |d|^2 is split in two halves for the multiply.
  // ---------------------------------------------------------------------------
  logic [65:0]  dsq12_r;
  logic [35:0]  numsq12_r;
  logic [63:0]  densq12_r, densq13_r;
  logic         near12_r, near13_r;
  logic [68:0]  plo13_r, phi13_r;
  logic         reach14_r;
  logic [101:0] lhs14, rhs14;

  always_ff @(posedge clk) begin
    dsq12_r   <= 66'(sq11_r[0]) + 66'(sq11_r[1]) + 66'(sq11_r[2]);
    numsq12_r <= numsq11_r;
    densq12_r <= densq11_r;
    near12_r  <= near11_r;
    plo13_r   <= 69'(dsq12_r[32:0]) * 69'(numsq12_r);
    phi13_r   <= 69'(dsq12_r[65:33]) * 69'(numsq12_r);
    densq13_r <= densq12_r;
    near13_r  <= near12_r;
    reach14_r <= near13_r && (lhs14 < rhs14);
  end

  assign lhs14 = (102'(phi13_r) << 33) + 102'(plo13_r);
  assign rhs14 = 102'(densq13_r) << 36;

  // ---------------------------------------------------------------------------
  // Stages 12..45: hit coordinates cam + round(d_c*num/den), one divider per axis.
  // ---------------------------------------------------------------------------
  logic [31:0] coord [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    rwnh_div u_div (
      .clk    (clk),
      .prod_i (m11_r[c]),
      .den_i  (den11_r),
      .cam_i  (cam11_r[c]),
      .neg_i  (neg11_r[c]),
      .coord_o(coord[c])
    );
  end

  // flags ride alongside the dividers
  localparam int REACH_LINE = DIV_LAT - 3;

  logic vld_line_r   [DIV_LAT];
  logic found_line_r [DIV_LAT];
  logic reach_line_r [REACH_LINE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_LAT; s++) vld_line_r[s] <= 1'b0;
    end else begin
      vld_line_r[0] <= vld11_r;
      for (int s = 1; s < DIV_LAT; s++) vld_line_r[s] <= vld_line_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    found_line_r[0] <= found11_r;
    for (int s = 1; s < DIV_LAT; s++) found_line_r[s] <= found_line_r[s-1];
    reach_line_r[0] <= reach14_r;
    for (int s = 1; s < REACH_LINE; s++) reach_line_r[s] <= reach_line_r[s-1];
  end

  // ---------------------------------------------------------------------------
  // Stage 46: result register; no hit gives zeros and clear flags.
  // ---------------------------------------------------------------------------
  logic        out_valid_r;
  logic [31:0] out_hit_r [3];
  logic        out_found_r, out_reach_r;
  logic        found_end;

  assign found_end = found_line_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_line_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) out_hit_r[c] <= found_end ? coord[c] : '0;
    out_found_r <= found_end;
    out_reach_r <= found_end && reach_line_r[REACH_LINE-1];
  end

  assign out_valid        = out_valid_r;
  assign out_hit_x        = out_hit_r[0];
  assign out_hit_y        = out_hit_r[1];
  assign out_hit_z        = out_hit_r[2];
  assign out_hit_found    = out_found_r;
  assign out_within_reach = out_reach_r;

endmodule

// File: src/rwnh_chk.sv
// Port-level checker for ray_wall_nearest_hit, bound to the top level.
// Depends on rwnh_pkg (OUT_LAT).
module rwnh_chk import rwnh_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_hit_x,
  input logic [31:0] out_hit_y,
  input logic [31:0] out_hit_z,
  input logic        out_hit_found,
  input logic        out_within_reach
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##OUT_LAT out_valid)
    else $error("request without result");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, OUT_LAT))
    else $error("result without request");

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit_found) |->
      (out_hit_x == '0) && (out_hit_y == '0) && (out_hit_z == '0) && !out_within_reach)
    else $error("no hit but nonzero result");

endmodule

bind ray_wall_nearest_hit rwnh_chk u_rwnh_chk (.*);
